>>> src/pedd_pkg.sv
// Shared types, constants and arithmetic helpers for the palette error-diffusion dither core.
// Depends on nothing; every source file but pedd_ram imports it.
package pedd_pkg;

    localparam int PALETTE_DEPTH = 16;
    localparam int PAL_IDX_W     = 4;
    localparam int MAX_WIDTH     = 2048;
    localparam int COL_W         = 11;
    localparam int ROW_W         = 16;
    localparam int ERR_W         = 12;
    localparam int CUR_W         = 13;
    localparam int SQ_W          = 23;
    localparam int DIST_W        = 25;

    // transaction kinds on the input stream (tuser)
    localparam logic MODE_PIXEL   = 1'b0;
    localparam logic MODE_PALETTE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_PALETTE_COUNT = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [4:0]  PCOUNT_RST = 5'd16;
    localparam logic [11:0] WIDTH_RST  = 12'd2048;
    localparam logic [15:0] HEIGHT_RST = 16'd65535;

    // diffusion weights, all over 16
    localparam logic [2:0] DIFF_W_RIGHT       = 3'd7;
    localparam logic [2:0] DIFF_W_LOWER_LEFT  = 3'd3;
    localparam logic [2:0] DIFF_W_BELOW       = 3'd5;
    localparam logic [2:0] DIFF_W_LOWER_RIGHT = 3'd1;

    localparam logic signed [13:0] SUM_MAX = 14'sd2047;
    localparam logic signed [13:0] SUM_MIN = -14'sd2048;
    localparam logic signed [11:0] ERR_MAX = 12'sh7FF;
    localparam logic signed [11:0] ERR_MIN = 12'sh800;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pedd_rgb_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] b;
        logic signed [ERR_W-1:0] g;
        logic signed [ERR_W-1:0] r;
    } pedd_err_t;

    typedef struct packed {
        logic signed [CUR_W-1:0] b;
        logic signed [CUR_W-1:0] g;
        logic signed [CUR_W-1:0] r;
    } pedd_cur_t;

    typedef struct packed {
        logic                 clear;
        logic                 issue;
        logic [PAL_IDX_W-1:0] idx;
    } pedd_srch_ctl_t;

    typedef struct packed {
        logic                 done;
        logic [PAL_IDX_W-1:0] best_idx;
        pedd_rgb_t            best_rgb;
    } pedd_srch_stat_t;

    function automatic logic signed [ERR_W-1:0] sat12(input logic signed [13:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > SUM_MAX)
            r = ERR_MAX;
        else if (v < SUM_MIN)
            r = ERR_MIN;
        else
            r = v[ERR_W-1:0];
        return r;
    endfunction

    function automatic logic signed [ERR_W-1:0] chan_sum(input logic signed [ERR_W-1:0] a,
                                                         input logic signed [ERR_W-1:0] b);
        return sat12(14'(a) + 14'(b));
    endfunction

    function automatic logic signed [CUR_W-1:0] chan_cur(input logic [7:0] pix,
                                                         input logic signed [ERR_W-1:0] below,
                                                         input logic signed [ERR_W-1:0] rc);
        logic signed [ERR_W-1:0] tot;
        tot = chan_sum(below, rc);
        return $signed({5'b0, pix}) + 13'(tot);
    endfunction

    // weighted part over 16, truncated toward zero
    function automatic logic signed [ERR_W-1:0] chan_part(input logic signed [CUR_W-1:0] e,
                                                          input logic [2:0] wt);
        logic signed [16:0] p;
        logic signed [16:0] q;
        p = 17'(e) * $signed({14'b0, wt});
        if (p < 0)
            p = p + 17'sd15;
        q = p >>> 4;
        return q[ERR_W-1:0];
    endfunction

    function automatic logic signed [CUR_W-1:0] chan_err(input logic signed [CUR_W-1:0] c,
                                                         input logic [7:0] pal);
        return c - $signed({5'b0, pal});
    endfunction

    function automatic pedd_cur_t cur_from(input pedd_rgb_t pix, input pedd_err_t below,
                                           input pedd_err_t rc);
        pedd_cur_t c;
        c.r = chan_cur(pix.r, below.r, rc.r);
        c.g = chan_cur(pix.g, below.g, rc.g);
        c.b = chan_cur(pix.b, below.b, rc.b);
        return c;
    endfunction

    function automatic pedd_err_t err_part(input pedd_cur_t c, input pedd_rgb_t p,
                                           input logic [2:0] wt);
        pedd_err_t e;
        e.r = chan_part(chan_err(c.r, p.r), wt);
        e.g = chan_part(chan_err(c.g, p.g), wt);
        e.b = chan_part(chan_err(c.b, p.b), wt);
        return e;
    endfunction

    function automatic pedd_err_t err_add(input pedd_err_t a, input pedd_err_t b);
        pedd_err_t s;
        s.r = chan_sum(a.r, b.r);
        s.g = chan_sum(a.g, b.g);
        s.b = chan_sum(a.b, b.b);
        return s;
    endfunction

endpackage

>>> src/pedd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; used for the palette store and the next-row error line.
module pedd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/pedd_search.sv
// Nearest-palette search: squares one palette entry per cycle, then sums and keeps the best.
// Depends on pedd_pkg; fed by the palette RAM read port.
module pedd_search
    import pedd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  pedd_srch_ctl_t  ctl,
    input  pedd_cur_t       cur,
    input  pedd_rgb_t       pal_rdata,
    output pedd_srch_stat_t stat
);

    logic                 v1_reg;
    logic [PAL_IDX_W-1:0] idx1_reg;
    logic                 v2_reg;
    logic [PAL_IDX_W-1:0] idx2_reg;
    pedd_rgb_t            rgb2_reg;
    logic [SQ_W-1:0]      sq_r_reg;
    logic [SQ_W-1:0]      sq_g_reg;
    logic [SQ_W-1:0]      sq_b_reg;
    logic                 have_reg;
    logic [DIST_W-1:0]    best_d_reg;
    logic [PAL_IDX_W-1:0] best_idx_reg;
    pedd_rgb_t            best_rgb_reg;

    logic signed [CUR_W-1:0]   d_r;
    logic signed [CUR_W-1:0]   d_g;
    logic signed [CUR_W-1:0]   d_b;
    logic signed [2*CUR_W-1:0] p_r;
    logic signed [2*CUR_W-1:0] p_g;
    logic signed [2*CUR_W-1:0] p_b;
    logic [DIST_W-1:0]         dist_sum;
    logic                      better;

    always_comb
    begin
        d_r = chan_err(cur.r, pal_rdata.r);
        d_g = chan_err(cur.g, pal_rdata.g);
        d_b = chan_err(cur.b, pal_rdata.b);
        p_r = d_r * d_r;
        p_g = d_g * d_g;
        p_b = d_b * d_b;
    end

    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    // strict compare in index order keeps the lowest index on a tie
    assign better   = !have_reg || (dist_sum < best_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            have_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            if (v2_reg)
                have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= ctl.idx;
        if (v1_reg)
        begin
            idx2_reg <= idx1_reg;
            rgb2_reg <= pal_rdata;
            sq_r_reg <= p_r[SQ_W-1:0];
            sq_g_reg <= p_g[SQ_W-1:0];
            sq_b_reg <= p_b[SQ_W-1:0];
        end
        if (v2_reg && better)
        begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= idx2_reg;
            best_rgb_reg <= rgb2_reg;
        end
    end

    // done: the last compare lands this cycle, nothing left behind it
    assign stat.done     = v2_reg && !v1_reg && !ctl.issue;
    assign stat.best_idx = best_idx_reg;
    assign stat.best_rgb = best_rgb_reg;

endmodule

>>> src/palette_error_diffusion_dither_core.sv
// Palette error-diffusion dither core: top level, sequencer, error line and output register.
// A transaction is accepted only in ST_IDLE; a pixel then passes through LOAD, SEARCH, DRAIN,
// CALC, APPLY, FLUSH (last column of a row that is not the frame's last only) and OUT before the
// next is taken. Its pace is set by the palette search: one entry per cycle through the palette
// RAM read port. Palette writes produce no result. Reset (rst_n, async, active low) clears
// position and carried errors and loads palette_count 16, image_width 2048, image_height 65535.
module palette_error_diffusion_dither_core
    import pedd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in, entry_index, zero pad
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out, chosen_index, pad
    output logic        m_axis_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_CALC   = 3'd4;
    localparam logic [2:0] ST_APPLY  = 3'd5;
    localparam logic [2:0] ST_FLUSH  = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [4:0]           pcount_reg;
    logic [11:0]          width_reg;
    logic [15:0]          height_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    pedd_err_t            rc_reg;      // error carried to the right neighbor
    pedd_err_t            lrp_reg;     // lower-right share waiting for the next column
    pedd_err_t            pend_reg;    // next-row sum for the column just left, not yet written
    logic [PAL_IDX_W-1:0] rd_idx_reg;
    pedd_rgb_t            pix_rgb_reg;
    logic [7:0]           alpha_reg;
    pedd_cur_t            cur_reg;
    pedd_err_t            p7_reg;
    pedd_err_t            p3_reg;
    pedd_err_t            p5_reg;
    pedd_err_t            p1_reg;
    logic                 out_valid_reg;
    pedd_rgb_t            out_rgb_reg;
    logic [7:0]           out_alpha_reg;
    logic [PAL_IDX_W-1:0] out_idx_reg;
    logic                 out_last_reg;

    logic                 in_acc;
    logic                 pix_acc;
    logic                 pal_acc;
    logic                 cfg_acc;
    logic                 out_free;
    pedd_rgb_t            in_rgb;
    logic [7:0]           in_alpha;
    logic [PAL_IDX_W-1:0] in_entry;
    logic [11:0]          w_eff;
    logic [15:0]          h_eff;
    logic [4:0]           cnt_eff;
    logic [PAL_IDX_W-1:0] last_idx;
    logic                 last_col;
    logic                 last_row;

    logic                 err_we;
    logic [COL_W-1:0]     err_waddr;
    pedd_err_t            err_wdata;
    logic                 err_re;
    pedd_err_t            err_rdata;
    pedd_err_t            below;
    pedd_rgb_t            pal_rdata;
    pedd_srch_ctl_t       srch_ctl;
    pedd_srch_stat_t      srch_stat;

    // ---------------------------------------------------------------- handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pix_acc       = in_acc && (s_axis_tuser == MODE_PIXEL);
    assign pal_acc       = in_acc && (s_axis_tuser == MODE_PALETTE);
    assign cfg_acc       = cfg_valid && cfg_ready;
    // the output register frees up in the same cycle its transaction completes
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign in_rgb   = s_axis_tdata[23:0];
    assign in_alpha = s_axis_tdata[31:24];
    assign in_entry = s_axis_tdata[35:32];

    // ---------------------------------------------------------------- effective geometry
    always_comb
    begin
        if (width_reg == 12'd0)
            w_eff = 12'd1;
        else if (width_reg > 12'(MAX_WIDTH))
            w_eff = 12'(MAX_WIDTH);
        else
            w_eff = width_reg;

        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;

        if (pcount_reg == 5'd0)
            cnt_eff = 5'd1;
        else if (pcount_reg > 5'(PALETTE_DEPTH))
            cnt_eff = 5'(PALETTE_DEPTH);
        else
            cnt_eff = pcount_reg;
    end

    assign last_idx = PAL_IDX_W'(cnt_eff - 5'd1);
    assign last_col = ({1'b0, col_reg} + 12'd1) >= w_eff;
    assign last_row = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};

    // ---------------------------------------------------------------- memories
    // Error line accesses are serialized by the sequencer: the read of column x is issued at
    // acceptance, writes to x-1 and x come later in the same pixel, so no two overlap.
    assign err_re    = pix_acc;
    assign err_we    = ((state_reg == ST_APPLY) && !last_row && (col_reg != '0))
                       || (state_reg == ST_FLUSH);
    assign err_waddr = (state_reg == ST_FLUSH) ? col_reg : col_reg - COL_W'(1);
    assign err_wdata = (state_reg == ST_FLUSH) ? pend_reg : err_add(pend_reg, p3_reg);

    pedd_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (3 * ERR_W)
    ) u_err_line (
        .clk   (clk),
        .we    (err_we),
        .waddr (err_waddr),
        .wdata (err_wdata),
        .re    (err_re),
        .raddr (col_reg),
        .rdata (err_rdata)
    );

    pedd_ram #(
        .DEPTH (PALETTE_DEPTH),
        .WIDTH (24)
    ) u_palette (
        .clk   (clk),
        .we    (pal_acc),
        .waddr (in_entry),
        .wdata (in_rgb),
        .re    (state_reg == ST_SEARCH),
        .raddr (rd_idx_reg),
        .rdata (pal_rdata)
    );

    // ---------------------------------------------------------------- search
    assign srch_ctl.clear = (state_reg == ST_LOAD);
    assign srch_ctl.issue = (state_reg == ST_SEARCH);
    assign srch_ctl.idx   = rd_idx_reg;

    pedd_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (srch_ctl),
        .cur       (cur_reg),
        .pal_rdata (pal_rdata),
        .stat      (srch_stat)
    );

    // row zero sees no error from above
    assign below = (row_reg == '0) ? '0 : err_rdata;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (pix_acc) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_SEARCH;
            ST_SEARCH: if (rd_idx_reg == last_idx) state_next = ST_DRAIN;
            ST_DRAIN:  if (srch_stat.done) state_next = ST_CALC;
            ST_CALC:   state_next = ST_APPLY;
            ST_APPLY:  state_next = (last_col && !last_row) ? ST_FLUSH : ST_OUT;
            ST_FLUSH:  state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state, position and carried errors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pcount_reg    <= PCOUNT_RST;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            rc_reg        <= '0;
            lrp_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // advance the palette read pointer during the search
            if (state_reg == ST_LOAD)
                rd_idx_reg <= '0;
            else if (state_reg == ST_SEARCH)
                rd_idx_reg <= rd_idx_reg + PAL_IDX_W'(1);

            // pass the right and lower-right shares on, and drop them at the end of each row
            if (state_reg == ST_APPLY)
            begin
                rc_reg <= last_col ? '0 : p7_reg;
                if (last_col)
                    lrp_reg <= '0;
                else if (!last_row)
                    lrp_reg <= p1_reg;
            end

            // load a new result, or drop the one just taken
            if ((state_reg == ST_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;

            // hand the result over and advance the raster position
            if ((state_reg == ST_OUT) && out_free)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end

            // a geometry write restarts the frame
            if (cfg_acc)
            begin
                case (cfg_index)
                    REG_PALETTE_COUNT:
                        pcount_reg <= cfg_data[4:0];
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_data[11:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                        rc_reg    <= '0;
                        lrp_reg   <= '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                        rc_reg     <= '0;
                        lrp_reg    <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            pix_rgb_reg <= in_rgb;
            alpha_reg   <= in_alpha;
        end

        // pixel plus error from above and from the left
        if (state_reg == ST_LOAD)
            cur_reg <= cur_from(pix_rgb_reg, below, rc_reg);

        // split the quantization error into its four shares
        if (state_reg == ST_CALC)
        begin
            p7_reg <= err_part(cur_reg, srch_stat.best_rgb, DIFF_W_RIGHT);
            p3_reg <= err_part(cur_reg, srch_stat.best_rgb, DIFF_W_LOWER_LEFT);
            p5_reg <= err_part(cur_reg, srch_stat.best_rgb, DIFF_W_BELOW);
            p1_reg <= err_part(cur_reg, srch_stat.best_rgb, DIFF_W_LOWER_RIGHT);
        end

        // hold the below share for this column until the next pixel adds its lower-left share
        if (state_reg == ST_APPLY)
            pend_reg <= err_add(lrp_reg, p5_reg);

        if ((state_reg == ST_OUT) && out_free)
        begin
            out_rgb_reg   <= srch_stat.best_rgb;
            out_alpha_reg <= alpha_reg;
            out_idx_reg   <= srch_stat.best_idx;
            out_last_reg  <= last_col && last_row;
        end
    end

    // ---------------------------------------------------------------- outputs
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_idx_reg, out_alpha_reg, out_rgb_reg};
    assign m_axis_tlast  = out_last_reg;

    // ---------------------------------------------------------------- checks
    a_err_line_noclash: assert property (@(posedge clk) disable iff (!rst_n)
        !(err_we && err_re))
        else $error("error line read and write in the same cycle");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < w_eff))
        else $error("column position beyond the row width");

    a_flush_not_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (!last_row && last_col))
        else $error("error line flush outside the last column of a carried row");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && !out_free) |=> (state_reg == ST_OUT))
        else $error("result left the sequencer while the output register was full");

endmodule

>>> tb/pedd_scoreboard_pkg.sv
// Scoreboard for the palette error-diffusion dither core: item and result types plus a class
// that models palette, error line and frame position and checks each output transaction.
// Depends on pedd_pkg for widths, register indexes, reset values and diffusion weights.
package pedd_scoreboard_pkg;
    import pedd_pkg::*;

    // one input transaction, fields from the highest bit down, mode (tuser) above the stream bits
    typedef struct packed {
        logic     mode;
        bit [3:0] entry;
        bit [7:0] alpha;
        bit [7:0] blue;
        bit [7:0] green;
        bit [7:0] red;
    } dither_item_t;

    typedef struct packed {
        bit       frame_end;
        bit [3:0] index;
        bit [7:0] alpha;
        bit [7:0] blue;
        bit [7:0] green;
        bit [7:0] red;
    } dither_color_t;

    class dither_scoreboard;
        bit [7:0]      palette [PALETTE_DEPTH][3];
        bit [4:0]      count_reg;
        bit [11:0]     width_reg;
        bit [15:0]     height_reg;
        int            row_err [MAX_WIDTH][3];
        int            right_err [3];
        int            lower_right_err [3];
        int            col;
        int            row;
        dither_color_t chosen_q [$];
        int            errors;

        function new();
            count_reg  = PCOUNT_RST;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            col = 0;
            row = 0;
            for (int c = 0; c < 3; c++) begin
                right_err[c]       = 0;
                lower_right_err[c] = 0;
            end
        endfunction

        static function int clamp12(int v);
            if (v > 2047)
                return 2047;
            if (v < -2048)
                return -2048;
            return v;
        endfunction

        // weighted part of an error over 16, truncated toward zero
        static function int share(logic [2:0] wt, int e);
            return (int'(wt) * e) / 16;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] data);
            case (index)
                REG_PALETTE_COUNT: count_reg = data[4:0];
                REG_IMAGE_WIDTH:
                begin
                    width_reg = data[11:0];
                    restart();
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_reg = data;
                    restart();
                end
                default: ;
            endcase
        endfunction

        // dither one pixel, or load a palette slot
        function void take_item(dither_item_t it);
            int            w, h, n, x, y, best, best_d, d, t, below;
            int            pix [3];
            int            cur [3];
            int            err [3];
            bit            last_col, last_row;
            dither_color_t res;
            if (it.mode == MODE_PALETTE) begin
                palette[it.entry][0] = it.red;
                palette[it.entry][1] = it.green;
                palette[it.entry][2] = it.blue;
                return;
            end
            pix[0] = it.red;
            pix[1] = it.green;
            pix[2] = it.blue;
            w = (width_reg == 0) ? 1 : width_reg;
            if (w > MAX_WIDTH)
                w = MAX_WIDTH;
            h = (height_reg == 0) ? 1 : height_reg;
            n = (count_reg == 0) ? 1 : count_reg;
            if (n > PALETTE_DEPTH)
                n = PALETTE_DEPTH;
            x = col;
            y = row;
            if (x >= w)
                x = w - 1;
            last_col = (x + 1 >= w);
            last_row = (y + 1 >= h);

            for (int c = 0; c < 3; c++) begin
                below  = (y == 0) ? 0 : row_err[x][c];
                cur[c] = pix[c] + clamp12(below + right_err[c]);
            end

            best   = 0;
            best_d = -1;
            for (int i = 0; i < n; i++) begin
                d = 0;
                for (int c = 0; c < 3; c++) begin
                    t = cur[c] - int'(palette[i][c]);
                    d += t * t;
                end
                if (best_d < 0 || d < best_d) begin
                    best_d = d;
                    best   = i;
                end
            end

            for (int c = 0; c < 3; c++) begin
                err[c]       = cur[c] - int'(palette[best][c]);
                right_err[c] = last_col ? 0 : clamp12(share(DIFF_W_RIGHT, err[c]));
            end

            if (!last_row) begin
                for (int c = 0; c < 3; c++) begin
                    if (x > 0)
                        row_err[x-1][c] = clamp12(row_err[x-1][c]
                                                  + share(DIFF_W_LOWER_LEFT, err[c]));
                    row_err[x][c] = clamp12(lower_right_err[c] + share(DIFF_W_BELOW, err[c]));
                    lower_right_err[c] = last_col ? 0 : share(DIFF_W_LOWER_RIGHT, err[c]);
                end
            end

            res.red       = palette[best][0];
            res.green     = palette[best][1];
            res.blue      = palette[best][2];
            res.alpha     = it.alpha;
            res.index     = 4'(best);
            res.frame_end = 1'b0;

            x++;
            if (x >= w) begin
                x = 0;
                for (int c = 0; c < 3; c++) begin
                    right_err[c]       = 0;
                    lower_right_err[c] = 0;
                end
                y++;
                if (y >= h) begin
                    y             = 0;
                    res.frame_end = 1'b1;
                end
            end
            col = x;
            row = y;
            chosen_q.push_back(res);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            end
        endfunction

        function void check_output(logic [39:0] data, logic frame_end);
            dither_color_t e;
            if (chosen_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, tdata %h tlast %b",
                         $time, data, frame_end);
                return;
            end
            e = chosen_q.pop_front();
            check_field("red_out", e.red, data[7:0]);
            check_field("green_out", e.green, data[15:8]);
            check_field("blue_out", e.blue, data[23:16]);
            check_field("alpha_out", e.alpha, data[31:24]);
            check_field("chosen_index", e.index, data[35:32]);
            check_field("frame_end", e.frame_end, frame_end);
        endfunction

        function int pending();
            return chosen_q.size();
        endfunction
    endclass

endpackage

>>> tb/tb_palette_error_diffusion_dither_core.sv
// Testbench for palette_error_diffusion_dither_core: drives palette loads and pixels through
// the input stream under random bursts and output stalls, reprograms geometry between phases.
// Depends on pedd_pkg and pedd_scoreboard_pkg; needs nothing else but the RTL.
module tb_palette_error_diffusion_dither_core;
    import pedd_pkg::*;
    import pedd_scoreboard_pkg::*;

    // index with no register behind it; a write must change nothing
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int HOLD_CYCLES   = 400;   // long output hold-off, block must back up
    localparam int SETTLE_CYCLES = 40;    // long enough for the slowest pixel
    localparam int STALL_LIMIT   = 3000;  // cycles with no transaction anywhere

    typedef enum int {MIX_NORMAL, MIX_BRIGHT, MIX_DARK} pixel_mix_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_FOURTH} rx_style_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = MODE_PIXEL;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = REG_PALETTE_COUNT;
    logic [15:0] cfg_data      = '0;

    dither_scoreboard sb;
    int               results_seen = 0;
    int               burst_left   = 0;
    int               idle_cycles  = 0;
    int               rx_hold      = 0;
    int               holds_done   = 0;
    int               style_left   = 0;
    int               rx_tick      = 0;
    rx_style_t        rx_style     = RX_OPEN;

    always #5 clk = ~clk;

    palette_error_diffusion_dither_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Monitor: every handshake is sampled at the edge that completes it. Check the output
    // first; a pixel accepted at this edge cannot have its result out yet.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_output(m_axis_tdata, m_axis_tlast);
                results_seen <= results_seen + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.take_item(dither_item_t'({s_axis_tuser, s_axis_tdata[35:0]}));
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_palette_error_diffusion_dither_core: errors");
            $finish;
        end
    end

    // Receiver: stall on a pattern that changes style at random intervals, and twice hold
    // off for a long stretch so the pipeline fills and the input side stalls.
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else if ((holds_done == 0 && results_seen >= 300)
                 || (holds_done == 1 && results_seen >= 1000)) begin
            holds_done++;
            rx_hold = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else begin
            if (style_left == 0) begin
                rx_style   = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(16, 128);
            end
            style_left--;
            rx_tick++;
            case (rx_style)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= (rx_tick % 4 == 0);
            endcase
        end
    end

    function automatic dither_item_t palette_item(int slot, int r, int g, int b);
        dither_item_t it;
        it.mode  = MODE_PALETTE;
        it.entry = 4'(slot);
        it.alpha = 8'($urandom_range(0, 255));   // ignored by the block, toggle it anyway
        it.red   = 8'(r);
        it.green = 8'(g);
        it.blue  = 8'(b);
        return it;
    endfunction

    function automatic dither_item_t pixel_item(int r, int g, int b, int a);
        dither_item_t it;
        it.mode  = MODE_PIXEL;
        it.entry = 4'($urandom_range(0, 15));    // don't care for pixels
        it.alpha = 8'(a);
        it.red   = 8'(r);
        it.green = 8'(g);
        it.blue  = 8'(b);
        return it;
    endfunction

    // channel value biased toward the two extremes
    function automatic int any_level();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Bright and dark mixes pile error up against a single black or white entry until the
    // sums saturate; the normal mix interleaves palette reloads with random pixels.
    function automatic dither_item_t make_item(pixel_mix_t mix);
        dither_item_t it;
        case (mix)
            MIX_BRIGHT:
                it = pixel_item($urandom_range(224, 255), $urandom_range(224, 255),
                                $urandom_range(224, 255), $urandom_range(0, 255));
            MIX_DARK:
                it = pixel_item($urandom_range(0, 31), $urandom_range(0, 31),
                                $urandom_range(0, 31), $urandom_range(0, 255));
            default:
                if ($urandom_range(0, 99) < 8)
                    it = palette_item($urandom_range(0, 15), any_level(), any_level(),
                                      any_level());
                else
                    it = pixel_item(any_level(), any_level(), any_level(),
                                    $urandom_range(0, 255));
        endcase
        return it;
    endfunction

    // Offer one transaction and hold it until accepted; open a random gap between bursts.
    // tvalid stays high across a burst, so it is only lowered when a gap starts.
    task automatic send_item(input dither_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {4'b0, it.entry, it.alpha, it.blue, it.green, it.red};
        s_axis_tuser  <= it.mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Wait for every expected result, then give a trailing palette write time to retire.
    task automatic wait_idle();
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drain, reprogram all three registers (junk in the unused upper bits), then stream.
    task automatic run_phase(input int cnt, input int w, input int h, input int n,
                             input pixel_mix_t mix);
        stop_sending();
        wait_idle();
        write_reg(REG_PALETTE_COUNT, {11'($urandom_range(0, 2047)), 5'(cnt)});
        write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        if (mix == MIX_BRIGHT)
            send_item(palette_item(0, 0, 0, 0));
        else if (mix == MIX_DARK)
            send_item(palette_item(0, 255, 255, 255));
        repeat (n) send_item(make_item(mix));
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every slot at reset geometry: primaries, black and white, and a duplicate pair
        // so an exact tie must resolve to the lower slot.
        send_item(palette_item(0, 0, 0, 0));
        send_item(palette_item(1, 255, 0, 0));
        send_item(palette_item(2, 0, 255, 0));
        send_item(palette_item(3, 0, 0, 255));
        send_item(palette_item(4, 128, 128, 128));
        send_item(palette_item(5, 128, 128, 128));
        for (int i = 6; i < 15; i++)
            send_item(palette_item(i, any_level(), any_level(), any_level()));
        send_item(palette_item(15, 255, 255, 255));

        // Exact hits carry no error, so the tie pixel still lands on the duplicate pair.
        send_item(pixel_item(0, 0, 0, 0));
        send_item(pixel_item(255, 255, 255, 255));
        send_item(pixel_item(128, 128, 128, 17));
        send_item(pixel_item(255, 0, 0, 128));
        send_item(pixel_item(0, 255, 0, 1));
        send_item(pixel_item(0, 0, 255, 254));
        send_item(pixel_item(200, 60, 10, 99));

        stop_sending();
        wait_idle();
        write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));

        run_phase(4, 5, 3, 150, MIX_NORMAL);
        run_phase(0, 3, 12, 60, MIX_BRIGHT);        // count zero searches slot 0 only
        run_phase(1, 4, 10, 60, MIX_DARK);
        run_phase(16, 1, 7, 150, MIX_NORMAL);       // single column: every pixel ends a row
        run_phase(31, 8, 4, 200, MIX_NORMAL);       // count above depth clamps
        run_phase(2, 0, 0, 80, MIX_NORMAL);         // zero geometry: every pixel ends a frame
        run_phase(9, 4095, 65535, 60, MIX_NORMAL);  // width above the line length clamps
        run_phase(16, 2048, 2, 40, MIX_NORMAL);
        repeat (4)
            run_phase($urandom_range(1, 16), $urandom_range(2, 12), $urandom_range(1, 6),
                      150, MIX_NORMAL);

        stop_sending();
        wait_idle();
        if (sb.errors == 0)
            $display("tb_palette_error_diffusion_dither_core: clean");
        else
            $display("tb_palette_error_diffusion_dither_core: errors");
        $finish;
    end

endmodule
